>>> rtl/cobsd_pkg.sv
// Shared types and constants for the COBS frame decoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package cobsd_pkg;

    // Field widths fixed by the frame format
    localparam int unsigned BYTE_BITS     = 8;
    localparam int unsigned LENGTH_BITS   = 16;
    localparam int unsigned CFG_ADDR_BITS = 3;
    localparam int unsigned CFG_DATA_BITS = 32;

    // Code byte that opens a segment with no restored zero after it
    localparam logic [BYTE_BITS-1:0] LONG_CODE = 8'hFF;

    // Reset value of the output limit: full range
    localparam logic [LENGTH_BITS-1:0] LIMIT_RESET = '1;

    // Default depth of the result queue between decode and output stage
    localparam int unsigned QUEUE_DEPTH_DEF = 4;

    // Configuration register word indexes
    typedef enum logic [0:0] {
        REG_OUTPUT_LIMIT = 1'b0
    } reg_idx_t;

    // Frame end status
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_ZERO     = 2'd1,
        ST_PAST_END = 2'd2,
        ST_OVERFLOW = 2'd3
    } status_t;

    // One encoded word in
    typedef struct packed {
        logic [BYTE_BITS-1:0]   data_byte;
        logic [LENGTH_BITS-1:0] frame_length;
        logic                   last_byte;
    } item_t;

    // One decoded word out
    typedef struct packed {
        logic [BYTE_BITS-1:0]   out_byte;
        logic                   byte_valid;
        logic                   frame_done;
        status_t                status;
        logic [LENGTH_BITS-1:0] out_length;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/cobsd_front.sv
// Decode front end: accepts encoded words, tracks frame state, builds results.
// Depends on cobsd_pkg; pushes into cobsd_queue.
`default_nettype none

module cobsd_front
    import cobsd_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   accept,
    input  wire item_t                  item,
    input  wire logic [LENGTH_BITS-1:0] output_limit,
    output      logic                   push_res,
    output      result_t                res
);

    logic                   disc_reg,   disc_next;
    logic [LENGTH_BITS-1:0] bpos_reg,   bpos_next;
    logic [LENGTH_BITS:0]   ncode_reg,  ncode_next;
    logic                   long_reg,   long_next;
    logic [LENGTH_BITS-1:0] ocount_reg, ocount_next;

    // Frame state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            disc_reg   <= 1'b0;
            bpos_reg   <= '0;
            ncode_reg  <= '0;
            long_reg   <= 1'b0;
            ocount_reg <= '0;
        end
        else
        begin
            disc_reg   <= disc_next;
            bpos_reg   <= bpos_next;
            ncode_reg  <= ncode_next;
            long_reg   <= long_next;
            ocount_reg <= ocount_next;
        end
    end

    // Per-word decode: drop after an error, else overflow, zero, code word or data word
    always_comb
    begin
        status_t                st;
        logic                   emit;
        logic [BYTE_BITS-1:0]   ob;
        logic [LENGTH_BITS:0]   target;
        logic                   clear;

        disc_next   = disc_reg;
        bpos_next   = bpos_reg;
        ncode_next  = ncode_reg;
        long_next   = long_reg;
        ocount_next = ocount_reg;
        push_res    = 1'b0;
        res         = '0;
        st          = ST_OK;
        emit        = 1'b0;
        ob          = '0;
        target      = {1'b0, bpos_reg} + {{(LENGTH_BITS+1-BYTE_BITS){1'b0}}, item.data_byte};
        clear       = 1'b0;

        if (accept)
        begin
            if (disc_reg)
            begin
                // dropping the rest of a failed frame
                clear = item.last_byte;
            end
            else
            begin
                priority if (ocount_reg >= output_limit)
                begin
                    st = ST_OVERFLOW;
                end
                else if (item.data_byte == '0)
                begin
                    st = ST_ZERO;
                end
                else if ({1'b0, bpos_reg} == ncode_reg)
                begin
                    // code word: restore a zero unless frame start or after 0xFF
                    emit       = (bpos_reg != '0) && !long_reg;
                    ncode_next = target;
                    long_next  = (item.data_byte == LONG_CODE);
                    if (target > {1'b0, item.frame_length})
                    begin
                        st   = ST_PAST_END;
                        emit = 1'b0;
                    end
                end
                else
                begin
                    emit = 1'b1;
                    ob   = item.data_byte;
                end

                if (st != ST_OK)
                begin
                    push_res       = 1'b1;
                    res.frame_done = 1'b1;
                    res.status     = st;
                    if (item.last_byte)
                        clear = 1'b1;
                    else
                        disc_next = 1'b1;
                end
                else
                begin
                    ocount_next = ocount_reg + {{(LENGTH_BITS-1){1'b0}}, emit};
                    bpos_next   = bpos_reg + {{(LENGTH_BITS-1){1'b0}}, 1'b1};
                    if (item.last_byte)
                    begin
                        push_res       = 1'b1;
                        res.out_byte   = ob;
                        res.byte_valid = emit;
                        res.frame_done = 1'b1;
                        res.status     = ST_OK;
                        res.out_length = ocount_next;
                        clear          = 1'b1;
                    end
                    else if (emit)
                    begin
                        push_res       = 1'b1;
                        res.out_byte   = ob;
                        res.byte_valid = 1'b1;
                    end
                end
            end

            if (clear)
            begin
                disc_next   = 1'b0;
                bpos_next   = '0;
                ncode_next  = '0;
                long_next   = 1'b0;
                ocount_next = '0;
            end
        end
    end

    // An error result never carries a byte
    a_err_no_byte: assert property (@(posedge clk) disable iff (!rst_n)
        push_res && (res.status != ST_OK) |-> !res.byte_valid)
        else $error("error result carries a byte");

    // A result either ends a frame or carries a byte
    a_no_empty_res: assert property (@(posedge clk) disable iff (!rst_n)
        push_res |-> (res.frame_done || res.byte_valid))
        else $error("empty result pushed");

    // The last word of a frame leaves clean frame state behind
    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && item.last_byte |=> !disc_reg && (bpos_reg == '0) && (ocount_reg == '0))
        else $error("frame state not cleared at last word");

endmodule

`default_nettype wire

>>> rtl/cobsd_queue.sv
// Short result queue between the decode front end and the output stage.
// Depends on cobsd_pkg for the result type.
`default_nettype none

module cobsd_queue
    import cobsd_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    wr_en,
    input  wire result_t wr_data,
    input  wire logic    rd_en,
    output      result_t rd_data,
    output      logic    full,
    output      logic    empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    result_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign rd_data = slot_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (rd_en)
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (wr_en && !rd_en)
            count_next = count_reg + CNT_W'(1);
        else if (rd_en && !wr_en)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Slot storage, no reset
    always_ff @(posedge clk)
    begin
        if (wr_en)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    // Fill count stays within the depth
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count out of range");

    // No write into a full queue unless it is also read, no read from an empty one
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && full && !rd_en) && !(rd_en && empty))
        else $error("queue overrun or underrun");

endmodule

`default_nettype wire

>>> rtl/cobsd_back.sv
// Output stage: holds the oldest result on the result port until popped.
// Depends on cobsd_pkg; drains cobsd_queue.
`default_nettype none

module cobsd_back
    import cobsd_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    q_empty,
    input  wire result_t q_data,
    output      logic    q_pop,
    input  wire logic    pop,
    output      logic    empty,
    output      result_t result
);

    logic    hold_reg, hold_next;
    result_t data_reg;

    // Refill whenever the held word leaves or nothing is held
    assign q_pop     = !q_empty && (!hold_reg || pop);
    assign hold_next = q_pop || (hold_reg && !pop);
    assign empty     = !hold_reg;
    assign result    = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hold_reg <= 1'b0;
        else
            hold_reg <= hold_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            data_reg <= q_data;
    end

endmodule

`default_nettype wire

>>> rtl/cobs_frame_decoder_unit.sv
// COBS frame decoder, top level: config register, decode front end, queue, output stage.
// Depends on cobsd_pkg, cobsd_front, cobsd_queue, cobsd_back.
//
// Decodes COBS-encoded frames one encoded word per cycle. Each input word carries
// the encoded byte, the frame length and a last flag; each result word carries a
// decoded byte, a frame-done marker with status (ok, zero in input, code past frame
// end, output overflow) and, for a good frame, the decoded length. A code word at the
// start of a frame or right after a 0xFF code yields no result unless it ends the
// frame; dropped words after an error yield none. One word is accepted every cycle
// while full is low; full rises when the result queue holds QUEUE_DEPTH words, so
// sustained rate is one word per cycle as long as the result side pops each cycle.
// A result enters the queue at the edge that accepts its word and moves on into the
// output register when it is empty or popped. The user must write output_limit over APB
// at word address 0 only while the block is idle; the block does not enforce it.
`default_nettype none

module cobs_frame_decoder_unit
    import cobsd_pkg::*;
#(
    parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // encoded side
    input  wire logic                     push,
    output      logic                     full,
    input  wire item_t                    item,
    // decoded side
    output      logic                     empty,
    input  wire logic                     pop,
    output      result_t                  result,
    // configuration
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [CFG_ADDR_BITS-1:0] paddr,
    input  wire logic [CFG_DATA_BITS-1:0] pwdata,
    output      logic [CFG_DATA_BITS-1:0] prdata,
    output      logic                     pready
);

    logic [LENGTH_BITS-1:0] limit_reg;
    logic                   cfg_wr;
    logic                   sel_limit;
    logic                   accept;
    logic                   push_res;
    result_t                res;
    logic                   q_pop;
    logic                   q_empty;
    result_t                q_data;

    // Configuration register
    assign pready    = 1'b1;
    assign sel_limit = (reg_idx_t'(paddr[2]) == REG_OUTPUT_LIMIT);
    assign cfg_wr    = psel && penable && pwrite && pready && sel_limit;
    assign prdata    = sel_limit
                     ? {{(CFG_DATA_BITS-LENGTH_BITS){1'b0}}, limit_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            limit_reg <= LIMIT_RESET;
        else if (cfg_wr)
            limit_reg <= pwdata[LENGTH_BITS-1:0];
    end

    assign accept = push && !full;

    // Decode front end
    cobsd_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .item         (item),
        .output_limit (limit_reg),
        .push_res     (push_res),
        .res          (res)
    );

    // Result queue
    cobsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (push_res),
        .wr_data (res),
        .rd_en   (q_pop),
        .rd_data (q_data),
        .full    (full),
        .empty   (q_empty)
    );

    // Output stage
    cobsd_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .pop     (pop),
        .empty   (empty),
        .result  (result)
    );

endmodule

`default_nettype wire
